[rtl/core/hull_curve_power_speed_map_core_macros.svh]
// assertion macros for the hull curve power/speed map core
// no dependencies; included by the top level before its assertions
`ifndef HULL_CURVE_POWER_SPEED_MAP_CORE_MACROS_SVH
`define HULL_CURVE_POWER_SPEED_MAP_CORE_MACROS_SVH

// same-cycle implication, skipped while reset is high
`define HCPSM_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, skipped while reset is high
`define HCPSM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/hcpsm_pkg.sv]
// shared types and constants of the hull curve power/speed map core
// no dependencies; used by hcpsm_div and the top level
package hcpsm_pkg;

   localparam logic [1:0] ACT_LOAD  = 2'd0;
   localparam logic [1:0] ACT_POWER = 2'd1;
   localparam logic [1:0] ACT_SPEED = 2'd2;

   localparam int         CNT_W     = 4;
   localparam logic [3:0] CNT_RESET = 4'd2;

   localparam logic [31:0] PMAX = 32'hFFFF_FFFF;
   localparam logic [15:0] SMAX = 16'hFFFF;

   // cube root search covers 0..2^17-1, msb first
   localparam logic [4:0] CBRT_MSB = 5'd16;

   localparam int DIV_NUM_W = 49;
   localparam int DIV_DEN_W = 32;

   typedef struct packed {
      logic [1:0]  action;
      logic [2:0]  point_index;
      logic [15:0] point_speed;
      logic [23:0] point_energy;
      logic [15:0] query_speed;
      logic [31:0] query_power;
   } req_type;

   typedef struct packed {
      logic [31:0] power_out;
      logic [15:0] speed_out;
      logic        saturated;
   } rsp_type;

   typedef struct packed {
      logic [15:0] speed;
      logic [23:0] energy;
   } point_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] num;
      logic [DIV_DEN_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic                 done;
      logic [DIV_NUM_W-1:0] quo;
   } div_rsp_type;

endpackage

[rtl/core/hcpsm_div.sv]
// serial restoring divider, one quotient bit per cycle
// depends on hcpsm_pkg
module hcpsm_div (
   input  logic                    clock,
   input  logic                    reset,
   input  hcpsm_pkg::div_req_type  div_req,
   output hcpsm_pkg::div_rsp_type  div_rsp
);

   localparam int NW = hcpsm_pkg::DIV_NUM_W;
   localparam int DW = hcpsm_pkg::DIV_DEN_W;
   localparam int CW = $clog2(NW);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [NW-1:0] work_ff, work_in;
   logic [DW:0]   rem_ff, rem_in;
   logic [DW-1:0] den_ff, den_in;
   logic [DW:0]   rem_sh;
   logic          ge;

   assign rem_sh = {rem_ff[DW-1:0], work_ff[NW-1]};
   assign ge     = rem_sh >= {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      work_in = work_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(NW - 1);
         work_in = div_req.num;
         rem_in  = '0;
         den_in  = div_req.den;
      end else if (busy_ff) begin
         // quotient bits shift in at the bottom as the dividend leaves the top
         work_in = {work_ff[NW-2:0], ge};
         rem_in  = ge ? (rem_sh - {1'b0, den_ff}) : rem_sh;
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      work_ff <= work_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quo  = work_ff;

endmodule

[rtl/core/hull_curve_power_speed_map_core.sv]
// Power/speed curve lookup with piecewise linear interpolation over a loaded table.
// Request channel req_* carries one item per transfer: a point load (action 0),
// a power-from-speed query (action 1) or a speed-from-power query (action 2);
// action 3 is taken and dropped. Loads and dropped items give no response.
// Each query gives one transfer on rsp_*. csr_* writes the active point count.
// A load is written to the point memory when it is accepted. A query walks the
// point memory one entry per read, then either interpolates (through the
// 49-step serial divider), scales by the cube of the speed ratio (up to
// three passes through the divider) or searches a cube root (17 steps,
// each with passes through the shared multiplier).
// One query is in flight at a time; the next request is taken as soon as the
// result sits in the output register, even if the receiver has not taken it.
// A stalled receiver holds the output register and the finished query waits
// in its last state until the register frees up.
// Reset clears the control state and sets the point count to two; the point
// memory is not cleared and an entry must be loaded before a query reads it.
// Depends on hcpsm_pkg, hcpsm_div and the macros header.
`include "hull_curve_power_speed_map_core_macros.svh"

module hull_curve_power_speed_map_core #(
   parameter int MAX_POINTS = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  hcpsm_pkg::req_type              req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output hcpsm_pkg::rsp_type              rsp_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [hcpsm_pkg::CNT_W-1:0]     csr_data
);

   localparam int         AW   = $clog2(MAX_POINTS);
   localparam logic [7:0] MAXP = 8'(MAX_POINTS);

   typedef enum logic [25:0] {
      S_IDLE      = 26'h0000001,
      S_FIRST     = 26'h0000002,
      S_LAST      = 26'h0000004,
      S_LAST_PP   = 26'h0000008,
      S_SCAN_RD   = 26'h0000010,
      S_SCAN_CHK  = 26'h0000020,
      S_SCAN_PP   = 26'h0000040,
      S_INT_MUL   = 26'h0000080,
      S_INT_DIV   = 26'h0000100,
      S_INT_WAIT  = 26'h0000200,
      S_INT_END   = 26'h0000400,
      S_INT_PMUL  = 26'h0000800,
      S_CUBE_MUL  = 26'h0001000,
      S_CUBE_DIV  = 26'h0002000,
      S_CUBE_WAIT = 26'h0004000,
      S_CB_S2     = 26'h0008000,
      S_CB_S3     = 26'h0010000,
      S_CB_R0     = 26'h0020000,
      S_CB_R1     = 26'h0040000,
      S_CB_R2     = 26'h0080000,
      S_CB_C2     = 26'h0100000,
      S_CB_C3     = 26'h0200000,
      S_CB_T0     = 26'h0400000,
      S_CB_T1     = 26'h0800000,
      S_CB_CMP    = 26'h1000000,
      S_DONE      = 26'h2000000
   } state_type;

   state_type state_ff, state_in;
   logic [hcpsm_pkg::CNT_W-1:0] count_ff;
   logic               rsp_valid_ff;
   hcpsm_pkg::rsp_type rsp_data_ff;

   hcpsm_pkg::point_type pt_mem [MAX_POINTS];
   hcpsm_pkg::point_type rd_ff;
   logic          mem_re, mem_we;
   logic [AW-1:0] rd_addr, wr_addr;

   logic          is_spd_ff;
   logic [15:0]   qv_ff;
   logic [31:0]   qp_ff;
   logic [15:0]   a_s_ff;
   logic [23:0]   a_e_ff;
   logic [31:0]   a_p_ff;
   logic [AW-1:0] i_ff;
   logic          neg_ff;
   logic [31:0]   den_ff;
   logic [23:0]   e_ff;
   logic [31:0]   x_ff;
   logic [1:0]    k_ff;
   logic [15:0]   ref_s_ff;
   logic [31:0]   ref_p_ff;
   logic [47:0]   s3_ff;
   logic [63:0]   acc_ff;
   logic [79:0]   rhs_ff;
   logic [50:0]   c3_ff;
   logic [16:0]   y_ff;
   logic [4:0]    bit_ff;
   logic [31:0]   res_power_ff;
   logic [15:0]   res_speed_ff;
   logic          res_sat_ff;

   logic [33:0]   mul_a;
   logic [31:0]   mul_b;
   logic [65:0]   prod_ff;

   hcpsm_pkg::div_req_type div_req;
   hcpsm_pkg::div_rsp_type div_rsp;

   logic          accept, load_out;
   logic [7:0]    count8, n8;
   logic [AW-1:0] last_idx;
   logic [31:0]   pp;
   logic          low_hit, high_hit, scan_hit;
   logic [15:0]   ref_s_sel;
   logic [31:0]   ref_p_sel;
   logic          e_up, s_up;
   logic [23:0]   e_mag;
   logic [15:0]   s_mag;
   logic [48:0]   q;
   logic [25:0]   e26;
   logic [17:0]   s18;
   logic [16:0]   cand, y_new;
   logic [82:0]   lhs;
   logic          cmp_ok, q_big;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign load_out  = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ready);

   // active point count, clamped to 2..MAX_POINTS
   assign count8   = {4'b0, count_ff};
   assign n8       = (count8 < 8'd2) ? 8'd2 : ((count8 > MAXP) ? MAXP : count8);
   assign last_idx = AW'(n8 - 8'd1);

   // point power from the product register, Q24.8
   assign pp = prod_ff[39:8];

   assign low_hit   = is_spd_ff ? (qp_ff <= a_p_ff) : (qv_ff <= a_s_ff);
   assign high_hit  = is_spd_ff ? (qp_ff >= pp) : (qv_ff >= rd_ff.speed);
   assign ref_s_sel = low_hit ? a_s_ff : rd_ff.speed;
   assign ref_p_sel = low_hit ? a_p_ff : pp;
   assign scan_hit  = is_spd_ff ? (qp_ff <= pp) : (qv_ff <= rd_ff.speed);

   assign e_up  = rd_ff.energy >= a_e_ff;
   assign e_mag = e_up ? (rd_ff.energy - a_e_ff) : (a_e_ff - rd_ff.energy);
   assign s_up  = rd_ff.speed >= a_s_ff;
   assign s_mag = s_up ? (rd_ff.speed - a_s_ff) : (a_s_ff - rd_ff.speed);

   assign q     = div_rsp.quo;
   assign q_big = |q[48:32];
   assign e26   = neg_ff ? ({2'b0, a_e_ff} - q[25:0]) : ({2'b0, a_e_ff} + q[25:0]);
   assign s18   = neg_ff ? ({2'b0, a_s_ff} - q[17:0]) : ({2'b0, a_s_ff} + q[17:0]);

   // cube root: keep the candidate bit when cand^3 * pref <= s^3 * p
   assign cand   = y_ff | (17'd1 << bit_ff);
   assign lhs    = 83'(acc_ff) + {prod_ff[50:0], 32'b0};
   assign cmp_ok = lhs <= 83'(rhs_ff);
   assign y_new  = cmp_ok ? cand : y_ff;

   // point memory ports
   assign mem_we  = accept && (req_data.action == hcpsm_pkg::ACT_LOAD) &&
                    ({5'b0, req_data.point_index} < MAXP);
   assign wr_addr = AW'(req_data.point_index);

   always_comb begin
      mem_re  = 1'b0;
      rd_addr = '0;
      case (state_ff)
         S_IDLE: begin
            mem_re = accept && (req_data.action == hcpsm_pkg::ACT_POWER ||
                                req_data.action == hcpsm_pkg::ACT_SPEED);
         end
         S_FIRST: begin
            mem_re  = 1'b1;
            rd_addr = last_idx;
         end
         S_SCAN_RD: begin
            mem_re  = 1'b1;
            rd_addr = i_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         pt_mem[wr_addr] <= {req_data.point_speed, req_data.point_energy};
      end
      if (mem_re) begin
         rd_ff <= pt_mem[rd_addr];
      end
   end

   // shared multiplier operands
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_FIRST, S_LAST, S_SCAN_CHK: begin
            mul_a = 34'(rd_ff.energy);
            mul_b = 32'(rd_ff.speed);
         end
         S_INT_MUL: begin
            if (is_spd_ff) begin
               mul_a = 34'(qp_ff - a_p_ff);
               mul_b = 32'(s_mag);
            end else begin
               mul_a = 34'(qv_ff - a_s_ff);
               mul_b = 32'(e_mag);
            end
         end
         S_INT_END: begin
            mul_a = 34'(e_ff);
            mul_b = 32'(qv_ff);
         end
         S_CUBE_MUL: begin
            mul_a = 34'(x_ff);
            mul_b = 32'(qv_ff);
         end
         S_CB_S2: begin
            mul_a = 34'(ref_s_ff);
            mul_b = 32'(ref_s_ff);
         end
         S_CB_S3: begin
            mul_a = 34'(prod_ff[31:0]);
            mul_b = 32'(ref_s_ff);
         end
         S_CB_R0: begin
            mul_a = 34'(prod_ff[31:0]);
            mul_b = qp_ff;
         end
         S_CB_R1: begin
            mul_a = 34'(s3_ff[47:32]);
            mul_b = qp_ff;
         end
         S_CB_C2: begin
            mul_a = 34'(cand);
            mul_b = 32'(cand);
         end
         S_CB_C3: begin
            mul_a = prod_ff[33:0];
            mul_b = 32'(cand);
         end
         S_CB_T0: begin
            mul_a = 34'(prod_ff[31:0]);
            mul_b = ref_p_ff;
         end
         S_CB_T1: begin
            mul_a = 34'(c3_ff[50:32]);
            mul_b = ref_p_ff;
         end
         default: ;
      endcase
   end

   assign div_req.start = (state_ff == S_INT_DIV) || (state_ff == S_CUBE_DIV);
   assign div_req.num   = prod_ff[48:0];
   assign div_req.den   = den_ff;

   hcpsm_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_data.action)
                  hcpsm_pkg::ACT_POWER: state_in = S_FIRST;
                  hcpsm_pkg::ACT_SPEED: begin
                     state_in = (req_data.query_power == '0) ? S_DONE : S_FIRST;
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_FIRST:   state_in = S_LAST;
         S_LAST:    state_in = S_LAST_PP;
         S_LAST_PP: begin
            if (low_hit || high_hit) begin
               if (is_spd_ff) begin
                  state_in = S_CB_S2;
               end else begin
                  state_in = (ref_s_sel == '0) ? S_DONE : S_CUBE_MUL;
               end
            end else begin
               state_in = S_SCAN_RD;
            end
         end
         S_SCAN_RD:  state_in = S_SCAN_CHK;
         S_SCAN_CHK: state_in = S_SCAN_PP;
         S_SCAN_PP:  state_in = scan_hit ? S_INT_MUL : S_SCAN_RD;
         S_INT_MUL:  state_in = S_INT_DIV;
         S_INT_DIV:  state_in = S_INT_WAIT;
         S_INT_WAIT: begin
            if (div_rsp.done) begin
               state_in = is_spd_ff ? S_DONE : S_INT_END;
            end
         end
         S_INT_END:  state_in = S_INT_PMUL;
         S_INT_PMUL: state_in = S_DONE;
         S_CUBE_MUL: state_in = S_CUBE_DIV;
         S_CUBE_DIV: state_in = S_CUBE_WAIT;
         S_CUBE_WAIT: begin
            if (div_rsp.done) begin
               state_in = (q_big || k_ff == 2'd2) ? S_DONE : S_CUBE_MUL;
            end
         end
         S_CB_S2:  state_in = S_CB_S3;
         S_CB_S3:  state_in = S_CB_R0;
         S_CB_R0:  state_in = S_CB_R1;
         S_CB_R1:  state_in = S_CB_R2;
         S_CB_R2:  state_in = S_CB_C2;
         S_CB_C2:  state_in = S_CB_C3;
         S_CB_C3:  state_in = S_CB_T0;
         S_CB_T0:  state_in = S_CB_T1;
         S_CB_T1:  state_in = S_CB_CMP;
         S_CB_CMP: state_in = (bit_ff == '0) ? S_DONE : S_CB_C2;
         S_DONE: begin
            if (load_out) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= hcpsm_pkg::CNT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid) begin
            count_ff <= csr_data;
         end
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      if (load_out) begin
         rsp_data_ff.power_out <= res_power_ff;
         rsp_data_ff.speed_out <= res_speed_ff;
         rsp_data_ff.saturated <= res_sat_ff;
      end
      case (state_ff)
         S_IDLE: begin
            qv_ff        <= req_data.query_speed;
            qp_ff        <= req_data.query_power;
            is_spd_ff    <= (req_data.action == hcpsm_pkg::ACT_SPEED);
            res_power_ff <= '0;
            res_speed_ff <= '0;
            res_sat_ff   <= 1'b0;
         end
         S_FIRST: begin
            a_s_ff <= rd_ff.speed;
            a_e_ff <= rd_ff.energy;
         end
         S_LAST: a_p_ff <= pp;
         S_LAST_PP: begin
            i_ff     <= AW'(1);
            ref_s_ff <= ref_s_sel;
            ref_p_ff <= ref_p_sel;
            x_ff     <= ref_p_sel;
            den_ff   <= 32'(ref_s_sel);
            k_ff     <= '0;
            y_ff     <= '0;
            bit_ff   <= hcpsm_pkg::CBRT_MSB;
            // zero reference speed: zero stays zero, anything else clips
            if (!is_spd_ff && (low_hit || high_hit) && (ref_s_sel == '0) &&
                (qv_ff != '0)) begin
               res_power_ff <= hcpsm_pkg::PMAX;
               res_sat_ff   <= 1'b1;
            end
         end
         S_SCAN_PP: begin
            if (scan_hit) begin
               den_ff <= is_spd_ff ? (pp - a_p_ff) : 32'(rd_ff.speed - a_s_ff);
               neg_ff <= is_spd_ff ? !s_up : !e_up;
            end else begin
               a_s_ff <= rd_ff.speed;
               a_e_ff <= rd_ff.energy;
               a_p_ff <= pp;
               i_ff   <= i_ff + 1'b1;
            end
         end
         S_INT_WAIT: begin
            if (div_rsp.done) begin
               if (!is_spd_ff) begin
                  e_ff <= e26[25] ? '0 : e26[23:0];
               end else if (s18[17]) begin
                  res_speed_ff <= '0;
               end else if (s18[16]) begin
                  res_speed_ff <= hcpsm_pkg::SMAX;
                  res_sat_ff   <= 1'b1;
               end else begin
                  res_speed_ff <= s18[15:0];
               end
            end
         end
         S_INT_PMUL: res_power_ff <= pp;
         S_CUBE_WAIT: begin
            if (div_rsp.done) begin
               if (q_big) begin
                  res_power_ff <= hcpsm_pkg::PMAX;
                  res_sat_ff   <= 1'b1;
               end else begin
                  res_power_ff <= q[31:0];
                  x_ff         <= q[31:0];
                  k_ff         <= k_ff + 1'b1;
               end
            end
         end
         S_CB_R0: s3_ff  <= prod_ff[47:0];
         S_CB_R1: acc_ff <= prod_ff[63:0];
         S_CB_R2: rhs_ff <= 80'(acc_ff) + {prod_ff[47:0], 32'b0};
         S_CB_T0: c3_ff  <= prod_ff[50:0];
         S_CB_T1: acc_ff <= prod_ff[63:0];
         S_CB_CMP: begin
            y_ff   <= y_new;
            bit_ff <= bit_ff - 1'b1;
            if (bit_ff == '0) begin
               res_speed_ff <= y_new[16] ? hcpsm_pkg::SMAX : y_new[15:0];
               res_sat_ff   <= y_new[16];
            end
         end
         default: ;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `HCPSM_ASSERT_NOW(a_div_done_waiting, clock, reset, div_rsp.done, (state_ff == S_INT_WAIT) || (state_ff == S_CUBE_WAIT), "divider finished outside a wait state")
   `HCPSM_ASSERT_NOW(a_scan_in_range, clock, reset, state_ff == S_SCAN_RD, (i_ff != '0) && (i_ff <= last_idx), "segment scan ran past the last point")
   `HCPSM_ASSERT_NOW(a_one_result_field, clock, reset, rsp_valid_ff, (rsp_data_ff.power_out == '0) || (rsp_data_ff.speed_out == '0), "response carries both power and speed")
   `HCPSM_ASSERT_NEXT(a_result_loaded, clock, reset, load_out, rsp_valid_ff && (state_ff == S_IDLE), "finished query did not reach the output register")

endmodule
